/* src/tkh_pkg.sv */
// Package for the top-k selection block: payload structs, heap entry type
// and fixed field widths. No dependencies.
package tkh_pkg;

	localparam int unsigned K_W     = 7;
	localparam int unsigned RANK_W  = 6;
	localparam int unsigned IDX_W   = 16;
	localparam int unsigned VAL_W   = 32;
	localparam logic [K_W-1:0] K_RESET = 7'd40;

	typedef struct packed {
		logic [IDX_W-1:0] item_index;
		logic [VAL_W-1:0] item_value;
		logic             last_item;
	} item_t;

	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic [IDX_W-1:0]  best_index;
		logic [VAL_W-1:0]  best_value;
		logic              last_result;
	} result_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] val;
	} entry_t;

endpackage

/* src/tkh_mem.sv */
// Heap storage: one write port and two read ports with registered read data.
// Depends on tkh_pkg for the entry type.
module tkh_mem #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  tkh_pkg::entry_t     wdata,
	input  logic [AW-1:0]       raddr_a,
	input  logic [AW-1:0]       raddr_b,
	output tkh_pkg::entry_t     rdata_a,
	output tkh_pkg::entry_t     rdata_b
);

	tkh_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

/* src/top_k_largest_min_heap.sv */
// Top-k largest selection over a stream, kept as a min-heap in one memory.
// A filling item is written straight into the heap; a full-heap item is read against
// the root and, when larger, replaces it and is sifted down by the read-compare-write
// loop. The first full item also builds the heap, about count/2 sifts. A report costs
// one delete-min sift per kept item, then emits the results one at a time, each held
// until taken. Reset clears control state and sets k to 40.
module top_k_largest_min_heap #(
	parameter int unsigned MAX_KEPT = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  tkh_pkg::item_t              item,
	output logic                        result_valid,
	input  logic                        result_stall,
	output tkh_pkg::result_t            result,
	input  logic                        cfg_wr_en,
	input  logic [tkh_pkg::K_W-1:0]     cfg_wr_data
);

	localparam int unsigned AW  = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int unsigned CW  = $clog2(MAX_KEPT + 1);
	localparam int unsigned CHW = AW + 2;
	localparam logic [tkh_pkg::K_W-1:0] K_MAX = tkh_pkg::K_W'(MAX_KEPT);

	typedef enum logic [3:0] {
		ST_IDLE, ST_BUILD_RD, ST_BUILD_LD, ST_SIFT_RD, ST_SIFT_CMP, ST_SIFT_DONE,
		ST_ROOT_RD, ST_ROOT_CMP, ST_DEL_RD, ST_DEL_LD, ST_EMIT_RD, ST_EMIT_LD
	} state_t;

	typedef enum logic [1:0] {MODE_BUILD, MODE_REPLACE, MODE_DELETE} mode_t;

	state_t               state_q;
	mode_t                mode_q;
	logic                 goal_report_q;
	logic                 heap_ok_q;
	logic [tkh_pkg::K_W-1:0] k_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        n_q;
	logic [CW-1:0]        total_q;
	logic [AW-1:0]        pos_q;
	logic [AW-1:0]        bi_q;
	logic [AW-1:0]        e_q;
	tkh_pkg::item_t       new_q;
	tkh_pkg::entry_t      hold_q;
	logic                 out_valid_q;
	tkh_pkg::result_t     out_q;

	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	tkh_pkg::entry_t      mem_wdata;
	logic [AW-1:0]        raddr_a;
	logic [AW-1:0]        raddr_b;
	tkh_pkg::entry_t      rdata_a;
	tkh_pkg::entry_t      rdata_b;

	logic [tkh_pkg::K_W-1:0] k_eff;
	logic                 accept;
	logic                 room;
	logic [CHW-1:0]       lc;
	logic [CHW-1:0]       rc;
	logic                 leaf;
	logic                 lt_l;
	logic                 sel_r;
	logic                 moving;
	tkh_pkg::entry_t      child;
	logic [CHW-1:0]       child_pos;
	tkh_pkg::entry_t      new_entry;

	tkh_mem #(.DEPTH(MAX_KEPT), .AW(AW)) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	assign item_stall   = (state_q != ST_IDLE);
	assign accept       = item_valid && !item_stall;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_comb begin
		if (k_q == '0) begin
			k_eff = tkh_pkg::K_W'(1);
		end else if (k_q > K_MAX) begin
			k_eff = K_MAX;
		end else begin
			k_eff = k_q;
		end
	end

	assign room      = tkh_pkg::K_W'(count_q) < k_eff;
	assign new_entry = '{idx: item.item_index, val: item.item_value};

	// Children of the current sift position; the moving element sits in hold_q.
	assign lc     = {1'b0, pos_q, 1'b1};
	assign rc     = lc + CHW'(1);
	assign leaf   = lc >= CHW'(n_q);
	assign lt_l   = rdata_a.val < hold_q.val;
	assign sel_r  = (rc < CHW'(n_q)) && (rdata_b.val < (lt_l ? rdata_a.val : hold_q.val));
	assign moving = lt_l || sel_r;
	assign child     = sel_r ? rdata_b : rdata_a;
	assign child_pos = sel_r ? rc : lc;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = hold_q;
		raddr_a   = '0;
		raddr_b   = AW'(n_q - CW'(1));
		unique case (state_q)
			ST_IDLE: begin
				if (accept && room) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(count_q);
					mem_wdata = new_entry;
				end
			end
			ST_BUILD_RD: begin
				raddr_a = bi_q;
			end
			ST_SIFT_RD: begin
				raddr_a = AW'(lc);
				raddr_b = AW'(rc);
				if (leaf) begin
					mem_we = 1'b1;
				end
			end
			ST_SIFT_CMP: begin
				mem_we = 1'b1;
				if (moving) begin
					mem_wdata = child;
				end
			end
			ST_DEL_LD: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(n_q - CW'(1));
				mem_wdata = rdata_a;
			end
			ST_EMIT_RD: begin
				raddr_a = e_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			mode_q        <= MODE_BUILD;
			goal_report_q <= 1'b0;
			heap_ok_q     <= 1'b0;
			k_q           <= tkh_pkg::K_RESET;
			count_q       <= '0;
			n_q           <= '0;
			total_q       <= '0;
			pos_q         <= '0;
			bi_q          <= '0;
			e_q           <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				k_q <= cfg_wr_data;
			end
			if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						new_q <= item;
						if (room) begin
							count_q   <= count_q + CW'(1);
							heap_ok_q <= 1'b0;
							if (item.last_item) begin
								bi_q          <= AW'((count_q + CW'(1)) >> 1);
								n_q           <= count_q + CW'(1);
								total_q       <= count_q + CW'(1);
								mode_q        <= MODE_BUILD;
								goal_report_q <= 1'b1;
								state_q       <= ST_BUILD_RD;
							end
						end else if (heap_ok_q) begin
							state_q <= ST_ROOT_RD;
						end else begin
							bi_q          <= AW'(count_q >> 1);
							n_q           <= count_q;
							mode_q        <= MODE_BUILD;
							goal_report_q <= 1'b0;
							state_q       <= ST_BUILD_RD;
						end
					end
				end
				ST_BUILD_RD: begin
					state_q <= ST_BUILD_LD;
				end
				ST_BUILD_LD: begin
					hold_q  <= rdata_a;
					pos_q   <= bi_q;
					state_q <= ST_SIFT_RD;
				end
				ST_SIFT_RD: begin
					state_q <= leaf ? ST_SIFT_DONE : ST_SIFT_CMP;
				end
				ST_SIFT_CMP: begin
					if (moving) begin
						pos_q   <= AW'(child_pos);
						state_q <= ST_SIFT_RD;
					end else begin
						state_q <= ST_SIFT_DONE;
					end
				end
				ST_SIFT_DONE: begin
					unique case (mode_q)
						MODE_BUILD: begin
							if (bi_q != '0) begin
								bi_q    <= bi_q - AW'(1);
								state_q <= ST_BUILD_RD;
							end else begin
								heap_ok_q <= 1'b1;
								if (goal_report_q) begin
									n_q     <= count_q;
									total_q <= count_q;
									state_q <= ST_DEL_RD;
								end else begin
									state_q <= ST_ROOT_RD;
								end
							end
						end
						MODE_REPLACE: begin
							if (new_q.last_item) begin
								n_q     <= count_q;
								total_q <= count_q;
								state_q <= ST_DEL_RD;
							end else begin
								state_q <= ST_IDLE;
							end
						end
						MODE_DELETE: begin
							if (n_q == '0) begin
								e_q     <= '0;
								state_q <= ST_EMIT_RD;
							end else begin
								state_q <= ST_DEL_RD;
							end
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_ROOT_RD: begin
					state_q <= ST_ROOT_CMP;
				end
				ST_ROOT_CMP: begin
					if (new_q.item_value > rdata_a.val) begin
						hold_q  <= '{idx: new_q.item_index, val: new_q.item_value};
						pos_q   <= '0;
						n_q     <= count_q;
						mode_q  <= MODE_REPLACE;
						state_q <= ST_SIFT_RD;
					end else if (new_q.last_item) begin
						n_q     <= count_q;
						total_q <= count_q;
						state_q <= ST_DEL_RD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DEL_RD: begin
					state_q <= ST_DEL_LD;
				end
				ST_DEL_LD: begin
					// The removed minimum lands in the slot just vacated, so the
					// memory ends up holding the report in rank order.
					hold_q  <= rdata_b;
					n_q     <= n_q - CW'(1);
					pos_q   <= '0;
					mode_q  <= MODE_DELETE;
					state_q <= ST_SIFT_RD;
				end
				ST_EMIT_RD: begin
					if (!out_valid_q) begin
						state_q <= ST_EMIT_LD;
					end
				end
				ST_EMIT_LD: begin
					out_valid_q       <= 1'b1;
					out_q.rank        <= tkh_pkg::RANK_W'(e_q);
					out_q.best_index  <= rdata_a.idx;
					out_q.best_value  <= rdata_a.val;
					out_q.last_result <= (CW'(e_q) == total_q - CW'(1));
					if (CW'(e_q) == total_q - CW'(1)) begin
						count_q   <= '0;
						heap_ok_q <= 1'b0;
						state_q   <= ST_IDLE;
					end else begin
						e_q     <= e_q + AW'(1);
						state_q <= ST_EMIT_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(count_q) <= CW'(MAX_KEPT))
		else $error("heap count exceeds capacity");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT_LD |-> !out_valid_q)
		else $error("result register loaded while still occupied");

	a_sift_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SIFT_CMP |-> lc < CHW'(n_q))
		else $error("sift compared a child outside the heap");

	a_del_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DEL_RD |-> n_q != '0)
		else $error("delete-min started on an empty heap");

	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT_LD |-> CW'(e_q) < total_q)
		else $error("report walked past the kept items");

endmodule
